// ===== rtl/ps2_mouse_packet_cursor_core_macros.svh =====
// Assertion helpers shared by the cursor core.
`ifndef PS2_MOUSE_PACKET_CURSOR_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in next cycle");

`endif

// ===== rtl/ps2mpc_pkg.sv =====
package ps2mpc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y = 2'd1;

    localparam logic signed [15:0] HOME_X_RESET = 16'sd15;
    localparam logic signed [15:0] HOME_Y_RESET = 16'sd10;

    // Bit positions in the first byte of a packet.
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_SYNC   = 3;
    localparam int BIT_SIGN_X = 4;
    localparam int BIT_SIGN_Y = 5;
    localparam int BIT_OVF_X  = 6;
    localparam int BIT_OVF_Y  = 7;

    typedef struct packed {
        logic       aux_data;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] old_x;
        logic signed [15:0] old_y;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic               left_button;
        logic               right_button;
        logic               middle_button;
        logic               home_jump;
    } t_out_item;

endpackage

// ===== rtl/ps2mpc_move.sv =====
module ps2mpc_move (
    input  logic [7:0]                i_first_byte,
    input  logic [7:0]                i_second_byte,
    input  logic [7:0]                i_third_byte,
    input  logic signed [15:0]        i_cursor_x,
    input  logic signed [15:0]        i_cursor_y,
    input  logic signed [15:0]        i_home_x,
    input  logic signed [15:0]        i_home_y,
    output ps2mpc_pkg::t_out_item     o_result
);

    // Nine-bit signed delta divided by ten, truncated toward zero.
    // The magnitude is at most 256, so a multiply by 205/2048 is exact.
    function automatic logic signed [5:0] f_div10(input logic [7:0] low, input logic neg);
        logic [8:0]  mag;
        logic [16:0] prod;
        logic [4:0]  q;
        mag  = neg ? (9'd256 - {1'b0, low}) : {1'b0, low};
        prod = {8'd0, mag} * 17'd205;
        q    = prod[15:11];
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [16:0] v);
        if (v[16] != v[15]) begin
            return v[16] ? 16'sh8000 : 16'sh7fff;
        end
        return v[15:0];
    endfunction

    logic signed [5:0]  w_dx;
    logic signed [5:0]  w_dy;
    logic signed [16:0] w_sum_x;
    logic signed [16:0] w_sum_y;
    logic               w_jump;

    assign w_dx = f_div10(i_second_byte, i_first_byte[ps2mpc_pkg::BIT_SIGN_X]);
    assign w_dy = f_div10(i_third_byte, i_first_byte[ps2mpc_pkg::BIT_SIGN_Y]);

    assign w_sum_x = {i_cursor_x[15], i_cursor_x} + {{11{w_dx[5]}}, w_dx};
    assign w_sum_y = {i_cursor_y[15], i_cursor_y} - {{11{w_dy[5]}}, w_dy};

    assign w_jump = i_first_byte[ps2mpc_pkg::BIT_LEFT];

    always_comb begin
        o_result.old_x         = i_cursor_x;
        o_result.old_y         = i_cursor_y;
        o_result.new_x         = w_jump ? i_home_x : f_sat16(w_sum_x);
        o_result.new_y         = w_jump ? i_home_y : f_sat16(w_sum_y);
        o_result.left_button   = i_first_byte[ps2mpc_pkg::BIT_LEFT];
        o_result.right_button  = i_first_byte[ps2mpc_pkg::BIT_RIGHT];
        o_result.middle_button = i_first_byte[ps2mpc_pkg::BIT_MIDDLE];
        o_result.home_jump     = w_jump;
    end

endmodule

// ===== rtl/ps2_mouse_packet_cursor_core.sv =====
// PS/2 mouse packet decoder with a saturating cursor.
// Input channel: i_valid, o_stall, i_item carries one controller byte and its
// auxiliary-data flag. Bytes without the flag are consumed and ignored.
// Output channel: o_valid, i_stall, o_result carries the cursor before and
// after one complete three-byte packet, the buttons and the home-jump flag.
// Configuration: i_cfg_we writes i_cfg_data to home_x (index 0) or home_y
// (index 1); other indexes are ignored. Write only while the block is idle.
// Each item is captured in an input register and then processed into the result
// register, so a result is valid once the third byte has passed through both
// registers. One item is accepted every cycle unless the output side stalls.
// When the receiver stalls a full result register, the result holds and the
// input side stalls once its input register is also occupied.
// Reset puts the packet phase at the first byte, the cursor at zero and the
// home position at column 15, row 10.
`include "ps2_mouse_packet_cursor_core_macros.svh"

module ps2_mouse_packet_cursor_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  ps2mpc_pkg::t_in_item                  i_item,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output ps2mpc_pkg::t_out_item                 o_result,
    input  logic                                  i_cfg_we,
    input  logic [ps2mpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ps2mpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    t_phase                r_phase;
    logic                  r_in_valid;
    ps2mpc_pkg::t_in_item  r_in;
    logic [7:0]            r_first;
    logic [7:0]            r_second;
    logic signed [15:0]    r_cursor_x;
    logic signed [15:0]    r_cursor_y;
    logic signed [15:0]    r_home_x;
    logic signed [15:0]    r_home_y;
    logic                  r_out_valid;
    ps2mpc_pkg::t_out_item r_out;

    ps2mpc_pkg::t_out_item w_move;
    logic                  w_slot_free;
    logic                  w_proc;
    logic                  w_overflow;
    logic                  w_emit;

    ps2mpc_move u_move (
        .i_first_byte  (r_first),
        .i_second_byte (r_second),
        .i_third_byte  (r_in.data_byte),
        .i_cursor_x    (r_cursor_x),
        .i_cursor_y    (r_cursor_y),
        .i_home_x      (r_home_x),
        .i_home_y      (r_home_y),
        .o_result      (w_move)
    );

    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_proc      = r_in_valid && w_slot_free && r_in.aux_data;
    assign w_overflow  = r_first[ps2mpc_pkg::BIT_OVF_X] || r_first[ps2mpc_pkg::BIT_OVF_Y];
    assign w_emit      = w_proc && (r_phase == PH_THIRD) && !w_overflow;

    assign o_stall  = r_in_valid && !w_slot_free;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_in_valid  <= 1'b0;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_home_x    <= ps2mpc_pkg::HOME_X_RESET;
            r_home_y    <= ps2mpc_pkg::HOME_Y_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
                r_in       <= i_item;
            end
            if (w_slot_free) begin
                r_out_valid <= w_emit;
            end
            if (w_emit) begin
                r_out      <= w_move;
                r_cursor_x <= w_move.new_x;
                r_cursor_y <= w_move.new_y;
            end
            if (w_proc) begin
                unique case (r_phase)
                    PH_SECOND: begin
                        r_second <= r_in.data_byte;
                        r_phase  <= PH_THIRD;
                    end
                    PH_THIRD: begin
                        r_phase <= PH_FIRST;
                    end
                    default: begin
                        r_first <= r_in.data_byte;
                        r_phase <= r_in.data_byte[ps2mpc_pkg::BIT_SYNC] ? PH_SECOND : PH_FIRST;
                    end
                endcase
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ps2mpc_pkg::CFG_HOME_X: r_home_x <= i_cfg_data;
                    ps2mpc_pkg::CFG_HOME_Y: r_home_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    `PMC_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `PMC_ASSERT_NOW(a_jump_means_left, i_clk, i_rst_n, o_valid,
                    o_result.home_jump == o_result.left_button)
    `PMC_ASSERT_NEXT(a_third_returns_first, i_clk, i_rst_n,
                     w_proc && (r_phase == PH_THIRD), r_phase == PH_FIRST)
    `PMC_ASSERT_NEXT(a_cursor_moves_on_result, i_clk, i_rst_n, !w_emit,
                     $stable(r_cursor_x) && $stable(r_cursor_y))

endmodule
